// ----- sv/jfte_pkg.sv -----
// Shared types, constants and axis mapping functions for the joystick frame
// trigger encoder. No dependencies.
package jfte_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int AXIS_W     = 8;
  localparam int TIME_W     = 32;
  localparam int THR_W      = 7;
  localparam int COOL_W     = 16;
  localparam int MAX_BYTES  = 6;
  localparam int CNT_W      = 3;
  localparam int IDX_W      = 3;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_DEADZONE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_MS       = 2'd2;

  localparam logic [THR_W-1:0]  THRESHOLD_RST = 7'd15;
  localparam logic [THR_W-1:0]  DEADZONE_RST  = 7'd10;
  localparam logic [COOL_W-1:0] COOLDOWN_RST  = 16'd5000;

  localparam logic [AXIS_W-1:0] MID_VALUE = 8'd128;
  localparam logic [AXIS_W-1:0] MAX_VALUE = 8'd255;
  localparam logic [AXIS_W-1:0] PKT_HEAD  = 8'hBB;
  localparam logic [AXIS_W-1:0] PKT_TAIL  = 8'hEE;
  localparam logic [AXIS_W-1:0] CMD_RX_LO = 8'h63;  // 'c'
  localparam logic [AXIS_W-1:0] CMD_RX_HI = 8'h64;  // 'd'
  localparam logic [AXIS_W-1:0] CMD_RY_LO = 8'h62;  // 'b'
  localparam logic [AXIS_W-1:0] CMD_RY_HI = 8'h61;  // 'a'

  typedef enum logic [1:0] {
    ZONE_CENTRE = 2'd0,
    ZONE_LOW    = 2'd1,
    ZONE_HIGH   = 2'd2
  } zone_t;

  typedef logic [AXIS_W-1:0] axis_t;

  function automatic axis_t snap_centre(input axis_t v, input logic [THR_W-1:0] dz);
    logic [AXIS_W-1:0] lo;
    logic [AXIS_W-1:0] hi;
    lo = MID_VALUE - {1'b0, dz};
    hi = MID_VALUE + {1'b0, dz};
    return (v >= lo && v <= hi) ? MID_VALUE : v;
  endfunction

  function automatic axis_t map_left(input logic [SAMPLE_W-1:0] s,
                                     input logic [THR_W-1:0] dz);
    logic [AXIS_W:0] v;
    v = 9'd256 - {1'b0, s[SAMPLE_W-1:4]};
    return snap_centre(v[AXIS_W] ? MAX_VALUE : v[AXIS_W-1:0], dz);
  endfunction

  function automatic axis_t map_right(input logic [SAMPLE_W-1:0] s,
                                      input logic [THR_W-1:0] dz);
    return snap_centre(s[SAMPLE_W-1:4], dz);
  endfunction

  function automatic zone_t zone_of(input axis_t v, input logic [THR_W-1:0] thr);
    zone_t z;
    if (v < {1'b0, thr}) begin
      z = ZONE_LOW;
    end else if (v > (MAX_VALUE - {1'b0, thr})) begin
      z = ZONE_HIGH;
    end else begin
      z = ZONE_CENTRE;
    end
    return z;
  endfunction

endpackage

// ----- sv/joystick_frame_trigger_encoder_top.sv -----
// Joystick frame trigger encoder: input register, byte assembly, output byte buffer.
// Depends on jfte_pkg.
// A frame's first byte is valid once its bytes load the output byte buffer.
// Throughput: one frame per cycle when frames emit nothing; otherwise one
// output byte per cycle while out_tready is high; a frame's run holds the buffer.
// Reset (rst_n low, synchronous): buffers empty, registers to defaults, Y zone
// centre, trigger times zero.
module joystick_frame_trigger_encoder_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // lx[11:0], ly[23:12], rx[35:24], ry[47:36], now_ms[79:48]
  input  logic [jfte_pkg::IN_DATA_W-1:0]        in_tdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // out_byte[7:0]
  output logic [jfte_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                  out_tlast,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [jfte_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [jfte_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import jfte_pkg::*;

  logic [THR_W-1:0]  threshold_r;
  logic [THR_W-1:0]  deadzone_r;
  logic [COOL_W-1:0] cooldown_r;

  zone_t             zone_r;
  logic [TIME_W-1:0] low_time_r;
  logic [TIME_W-1:0] high_time_r;

  logic                  s1_valid_r;
  logic [IN_DATA_W-1:0]  s1_data_r;

  axis_t                 buf_r [MAX_BYTES];
  logic [CNT_W-1:0]      cnt_r;
  logic [IDX_W-1:0]      idx_r;
  logic                  s2_valid_r;

  axis_t                 lx, ly, rx, ry;
  logic [TIME_W-1:0]     now;
  zone_t                 rxz, ryz;
  logic                  fire_lo, fire_hi;
  axis_t                 bytes_nxt [MAX_BYTES];
  logic [CNT_W-1:0]      n_nxt;
  logic                  out_last;
  logic                  s2_free;
  logic                  s1_adv;
  logic                  s1_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RST;
      deadzone_r  <= DEADZONE_RST;
      cooldown_r  <= COOLDOWN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TRIGGER_THRESHOLD: threshold_r <= cfg_data[THR_W-1:0];
        CFG_CENTER_DEADZONE:   deadzone_r  <= cfg_data[THR_W-1:0];
        CFG_COOLDOWN_MS:       cooldown_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    lx      = map_left(s1_data_r[11:0], deadzone_r);
    ly      = map_left(s1_data_r[23:12], deadzone_r);
    rx      = map_right(s1_data_r[35:24], deadzone_r);
    ry      = map_right(s1_data_r[47:36], deadzone_r);
    now     = s1_data_r[79:48];
    rxz     = zone_of(rx, threshold_r);
    ryz     = zone_of(ry, threshold_r);
    fire_lo = (ryz == ZONE_LOW) && (zone_r != ZONE_LOW) &&
              ((now - low_time_r) >= {{(TIME_W-COOL_W){1'b0}}, cooldown_r});
    fire_hi = (ryz == ZONE_HIGH) && (zone_r != ZONE_HIGH) &&
              ((now - high_time_r) >= {{(TIME_W-COOL_W){1'b0}}, cooldown_r});

    for (int i = 0; i < MAX_BYTES; i++) begin
      bytes_nxt[i] = '0;
    end
    n_nxt = '0;
    if (lx != MID_VALUE || ly != MID_VALUE) begin
      bytes_nxt[0] = PKT_HEAD;
      bytes_nxt[1] = ly;
      bytes_nxt[2] = lx;
      bytes_nxt[3] = PKT_TAIL;
      n_nxt        = 3'd4;
    end
    if (rx != MID_VALUE && rxz != ZONE_CENTRE) begin
      bytes_nxt[n_nxt] = (rxz == ZONE_LOW) ? CMD_RX_LO : CMD_RX_HI;
      n_nxt            = n_nxt + 3'd1;
    end
    if (fire_lo || fire_hi) begin
      bytes_nxt[n_nxt] = fire_lo ? CMD_RY_LO : CMD_RY_HI;
      n_nxt            = n_nxt + 3'd1;
    end
  end

  assign out_last  = (idx_r == (cnt_r - 3'd1));
  assign s2_free   = !s2_valid_r || (out_tready && out_last);
  assign s1_adv    = s1_valid_r && ((n_nxt == '0) || s2_free);
  assign in_tready = !s1_valid_r || s1_adv;
  assign s1_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_data_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r      <= ZONE_CENTRE;
      low_time_r  <= '0;
      high_time_r <= '0;
    end else if (s1_adv) begin
      zone_r <= ryz;
      if (fire_lo) begin
        low_time_r <= now;
      end
      if (fire_hi) begin
        high_time_r <= now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      idx_r      <= '0;
      cnt_r      <= '0;
    end else if (s2_free) begin
      s2_valid_r <= s1_adv && (n_nxt != '0);
      idx_r      <= '0;
      cnt_r      <= n_nxt;
    end else if (out_tready) begin
      idx_r <= idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      buf_r <= bytes_nxt;
    end
  end

  assign out_tvalid = s2_valid_r;
  assign out_tdata  = buf_r[idx_r];
  assign out_tlast  = out_last;

  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (cnt_r != '0) && (idx_r < cnt_r))
    else $error("byte index outside frame run");

  a_low_fire_zone: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(low_time_r) |-> (zone_r == ZONE_LOW))
    else $error("low trigger time moved outside low zone");

  a_high_fire_zone: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(high_time_r) |-> (zone_r == ZONE_HIGH))
    else $error("high trigger time moved outside high zone");

  a_stall_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && s2_valid_r)
    else $error("input stalled with free stages");

endmodule

// ----- tb/tb_joystick_frame_trigger_encoder_top.sv -----
// Testbench for joystick_frame_trigger_encoder_top: directed frames, then random phases
// under several register settings, with random stalls on both streams; results are scored
// against a built-in predictor. Depends on jfte_pkg and the top-level RTL.
`timescale 1ns / 100ps

module tb_joystick_frame_trigger_encoder_top;
  import jfte_pkg::*;

  localparam int DIRECTED_ROWS    = 26;
  localparam int RANDOM_PER_PHASE = 34;
  localparam int RANDOM_PHASES    = 6;
  localparam int SETTLE_CYCLES    = 4;
  localparam int CYCLE_LIMIT      = 400000;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
  localparam logic [SAMPLE_W-1:0]  MID_SAMPLE       = 12'h800;
  localparam logic [SAMPLE_W-1:0]  TOP_SAMPLE       = 12'hFFF;

  typedef struct packed {
    logic [SAMPLE_W-1:0] lx;
    logic [SAMPLE_W-1:0] ly;
    logic [SAMPLE_W-1:0] rx;
    logic [SAMPLE_W-1:0] ry;
    logic [TIME_W-1:0]   now;
  } frame_t;

  typedef struct packed {
    frame_t                    frame;
    logic                      typed;
    logic [2:0]                count;
    logic [0:MAX_BYTES-1][7:0] bytes;
  } directed_row_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } tx_byte_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  int          threshold_q   = int'(THRESHOLD_RST);
  int          deadzone_q    = int'(DEADZONE_RST);
  logic [15:0] cooldown_q    = COOLDOWN_RST;
  zone_t       y_zone_q      = ZONE_CENTRE;
  logic [31:0] low_fired_ms  = '0;
  logic [31:0] high_fired_ms = '0;

  logic [7:0] byte_run [$];
  tx_byte_t   pending_bytes [$];
  int         mismatches = 0;
  bit         quiet_tail = 1'b0;
  int         cycle_count;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{MID_SAMPLE, MID_SAMPLE, MID_SAMPLE, MID_SAMPLE, 32'd0}, 1'b1, 3'd0, 48'h0},
    '{'{12'h000, MID_SAMPLE, MID_SAMPLE, MID_SAMPLE, 32'd1}, 1'b1, 3'd4,
      {PKT_HEAD, 8'h80, 8'hFF, PKT_TAIL, 16'h0}},
    '{'{TOP_SAMPLE, TOP_SAMPLE, MID_SAMPLE, MID_SAMPLE, 32'd2}, 1'b1, 3'd4,
      {PKT_HEAD, 8'h01, 8'h01, PKT_TAIL, 16'h0}},
    '{'{MID_SAMPLE, MID_SAMPLE, 12'h000, MID_SAMPLE, 32'd3}, 1'b1, 3'd1, {CMD_RX_LO, 40'h0}},
    '{'{MID_SAMPLE, MID_SAMPLE, TOP_SAMPLE, MID_SAMPLE, 32'd4}, 1'b1, 3'd1, {CMD_RX_HI, 40'h0}},
    '{'{MID_SAMPLE, MID_SAMPLE, MID_SAMPLE, 12'h000, 32'd100}, 1'b1, 3'd0, 48'h0},
    '{'{MID_SAMPLE, MID_SAMPLE, MID_SAMPLE, MID_SAMPLE, 32'd200}, 1'b1, 3'd0, 48'h0},
    '{'{MID_SAMPLE, MID_SAMPLE, MID_SAMPLE, 12'h000, 32'd5000}, 1'b1, 3'd1, {CMD_RY_LO, 40'h0}},
    '{'{MID_SAMPLE, MID_SAMPLE, MID_SAMPLE, 12'h000, 32'd20000}, 1'b1, 3'd0, 48'h0},
    '{'{MID_SAMPLE, MID_SAMPLE, MID_SAMPLE, TOP_SAMPLE, 32'd20001}, 1'b1, 3'd1,
      {CMD_RY_HI, 40'h0}},
    '{'{MID_SAMPLE, MID_SAMPLE, MID_SAMPLE, 12'h000, 32'd20002}, 1'b1, 3'd1, {CMD_RY_LO, 40'h0}},
    '{'{MID_SAMPLE, MID_SAMPLE, MID_SAMPLE, TOP_SAMPLE, 32'd20003}, 1'b1, 3'd0, 48'h0},
    '{'{12'h000, TOP_SAMPLE, TOP_SAMPLE, 12'h000, 32'd30000}, 1'b1, 3'd6,
      {PKT_HEAD, 8'h01, 8'hFF, PKT_TAIL, CMD_RX_HI, CMD_RY_LO}},
    '{'{MID_SAMPLE, MID_SAMPLE, MID_SAMPLE, TOP_SAMPLE, 32'hFFFF_FF00}, 1'b1, 3'd1,
      {CMD_RY_HI, 40'h0}},
    '{'{MID_SAMPLE, MID_SAMPLE, MID_SAMPLE, MID_SAMPLE, 32'hFFFF_FF10}, 1'b1, 3'd0, 48'h0},
    '{'{MID_SAMPLE, MID_SAMPLE, MID_SAMPLE, TOP_SAMPLE, 32'h0000_1000}, 1'b1, 3'd0, 48'h0},
    '{'{MID_SAMPLE, MID_SAMPLE, MID_SAMPLE, MID_SAMPLE, 32'h0000_1200}, 1'b1, 3'd0, 48'h0},
    '{'{MID_SAMPLE, MID_SAMPLE, MID_SAMPLE, TOP_SAMPLE, 32'h0000_1400}, 1'b1, 3'd1,
      {CMD_RY_HI, 40'h0}},
    '{'{12'h8A0, MID_SAMPLE, MID_SAMPLE, MID_SAMPLE, 32'h0000_1500}, 1'b0, 3'd0, 48'h0},
    '{'{12'h8B0, MID_SAMPLE, MID_SAMPLE, MID_SAMPLE, 32'h0000_1501}, 1'b0, 3'd0, 48'h0},
    '{'{MID_SAMPLE, 12'h760, MID_SAMPLE, MID_SAMPLE, 32'h0000_1502}, 1'b0, 3'd0, 48'h0},
    '{'{MID_SAMPLE, 12'h750, MID_SAMPLE, MID_SAMPLE, 32'h0000_1503}, 1'b0, 3'd0, 48'h0},
    '{'{MID_SAMPLE, MID_SAMPLE, 12'h0E0, MID_SAMPLE, 32'h0000_1504}, 1'b0, 3'd0, 48'h0},
    '{'{MID_SAMPLE, MID_SAMPLE, 12'h0F0, MID_SAMPLE, 32'h0000_1505}, 1'b0, 3'd0, 48'h0},
    '{'{MID_SAMPLE, MID_SAMPLE, 12'hF10, MID_SAMPLE, 32'h0000_1506}, 1'b0, 3'd0, 48'h0},
    '{'{MID_SAMPLE, MID_SAMPLE, 12'hF00, MID_SAMPLE, 32'h0000_1507}, 1'b0, 3'd0, 48'h0}
  };

  joystick_frame_trigger_encoder_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int snapped(input int v);
    if (v >= int'(MID_VALUE) - deadzone_q && v <= int'(MID_VALUE) + deadzone_q) begin
      return int'(MID_VALUE);
    end
    return v;
  endfunction

  function automatic int left_axis(input logic [SAMPLE_W-1:0] s);
    int v;
    v = 256 - int'(s[SAMPLE_W-1:4]);
    if (v > int'(MAX_VALUE)) begin
      v = int'(MAX_VALUE);
    end
    return snapped(v);
  endfunction

  function automatic int right_axis(input logic [SAMPLE_W-1:0] s);
    return snapped(int'(s[SAMPLE_W-1:4]));
  endfunction

  function automatic zone_t axis_zone(input int v);
    if (v < threshold_q) begin
      return ZONE_LOW;
    end
    if (v > int'(MAX_VALUE) - threshold_q) begin
      return ZONE_HIGH;
    end
    return ZONE_CENTRE;
  endfunction

  function automatic void encode_frame(input frame_t f);
    int    lx;
    int    ly;
    zone_t rx_zone;
    zone_t ry_zone;
    lx = left_axis(f.lx);
    ly = left_axis(f.ly);
    rx_zone = axis_zone(right_axis(f.rx));
    ry_zone = axis_zone(right_axis(f.ry));
    byte_run = {};
    if (lx != int'(MID_VALUE) || ly != int'(MID_VALUE)) begin
      byte_run.push_back(PKT_HEAD);
      byte_run.push_back(8'(ly));
      byte_run.push_back(8'(lx));
      byte_run.push_back(PKT_TAIL);
    end
    if (rx_zone == ZONE_LOW) begin
      byte_run.push_back(CMD_RX_LO);
    end else if (rx_zone == ZONE_HIGH) begin
      byte_run.push_back(CMD_RX_HI);
    end
    if (ry_zone == ZONE_LOW && y_zone_q != ZONE_LOW &&
        32'(f.now - low_fired_ms) >= {16'd0, cooldown_q}) begin
      byte_run.push_back(CMD_RY_LO);
      low_fired_ms = f.now;
    end
    if (ry_zone == ZONE_HIGH && y_zone_q != ZONE_HIGH &&
        32'(f.now - high_fired_ms) >= {16'd0, cooldown_q}) begin
      byte_run.push_back(CMD_RY_HI);
      high_fired_ms = f.now;
    end
    y_zone_q = ry_zone;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 3))
      0: return 12'($urandom);
      1: return 12'($urandom_range(0, 12'h3FF));
      2: return 12'($urandom_range(12'hC00, 12'hFFF));
      default: return 12'($urandom_range(12'h600, 12'h9FF));
    endcase
  endfunction

  task automatic send_frame(input frame_t f, input logic typed, input logic [2:0] count,
                            input logic [0:MAX_BYTES-1][7:0] typed_bytes);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tdata  <= {f.now, f.ry, f.rx, f.ly, f.lx};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    encode_frame(f);
    if (typed) begin
      byte_run = {};
      for (int k = 0; k < count; k++) begin
        byte_run.push_back(typed_bytes[k]);
      end
    end
    foreach (byte_run[k]) begin
      pending_bytes.push_back('{byte_run[k], 1'(k == byte_run.size() - 1)});
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TRIGGER_THRESHOLD: threshold_q = int'(value[THR_W-1:0]);
      CFG_CENTER_DEADZONE:   deadzone_q  = int'(value[THR_W-1:0]);
      CFG_COOLDOWN_MS:       cooldown_q  = value[COOL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input int thr, input int dz, input int cool,
                              input logic poke_unused);
    write_reg(CFG_TRIGGER_THRESHOLD, {9'($urandom), 7'(thr)});
    write_reg(CFG_CENTER_DEADZONE, {9'($urandom), 7'(dz)});
    write_reg(CFG_COOLDOWN_MS, 16'(cool));
    if (poke_unused) begin
      write_reg(CFG_UNUSED_INDEX, 16'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : out_check
    tx_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_bytes.size() == 0) begin
        $error("out_byte: nothing expected, got %02h", out_tdata);
        mismatches++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_tdata !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, out_tdata);
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin : out_stall
    while (!rst_n) @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!quiet_tail) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    frame_t      f;
    logic [31:0] clock_ms;
    clock_ms = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[r]) begin
      send_frame(directed_rows[r].frame, directed_rows[r].typed, directed_rows[r].count,
                 directed_rows[r].bytes);
    end
    for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
      drain_results();
      case (phase)
        1: program_regs(0, 0, 0, 1'b0);
        2: program_regs(127, 127, 65535, 1'b0);
        3: program_regs(40, 5, 100, 1'b1);
        4: program_regs($urandom_range(0, 127), $urandom_range(0, 40),
                        $urandom_range(0, 3000), 1'b0);
        5: program_regs(127, 0, 1, 1'b0);
        default: program_regs(25, 12, 2000, 1'b0);
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        quiet_tail = (phase == RANDOM_PHASES && n >= RANDOM_PER_PHASE - 24);
        if ($urandom_range(0, 15) == 0) begin
          clock_ms = $urandom;
        end else begin
          clock_ms = clock_ms + $urandom_range(0, 2 * int'(cooldown_q) + 40);
        end
        f = '{pick_sample(), pick_sample(), pick_sample(), pick_sample(), clock_ms};
        send_frame(f, 1'b0, 3'd0, 48'h0);
      end
    end
    drain_results();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
